@@ hw/rtl/pngse_pkg.sv @@
// Shared types and constants of the stored-block PNG encoder.
package pngse_pkg;

    localparam int DIM_W        = 15;
    localparam logic [14:0] MAX_DIM = 15'd16384;
    localparam logic [15:0] STORED_BLOCK_MAX = 16'd65535;
    localparam logic [16:0] ADLER_MOD = 17'd65521;
    localparam logic [31:0] CRC_POLY  = 32'hedb88320;
    localparam logic [31:0] CRC_ONES  = 32'hffffffff;

    // Control for the checksum unit, one byte per request.
    typedef struct packed {
        logic       crc_en;
        logic       crc_init;
        logic       adler_en;
        logic       adler_clear;
        logic [7:0] data;
    } csum_ctl_t;

endpackage

@@ hw/rtl/pngse_csum.sv @@
// Running CRC-32 and Adler-32 over the emitted bytes.
module pngse_csum (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pngse_pkg::csum_ctl_t ctl,
    output logic [31:0]          crc,
    output logic [31:0]          adler
);
    import pngse_pkg::*;

    logic [31:0] crc_reg, crc_next;
    logic [15:0] low_reg, low_next, high_reg, high_next;
    logic [16:0] low_sum, high_sum;

    always_comb
    begin
        crc_next = (ctl.crc_init ? CRC_ONES : crc_reg) ^ {24'd0, ctl.data};
        for (int k = 0; k < 8; k++)
        begin
            crc_next = crc_next[0] ? ((crc_next >> 1) ^ CRC_POLY) : (crc_next >> 1);
        end
        low_sum  = {1'b0, low_reg} + {9'd0, ctl.data};
        low_next = (low_sum >= ADLER_MOD) ? 16'(low_sum - ADLER_MOD) : low_sum[15:0];
        high_sum = {1'b0, high_reg} + {1'b0, low_next};
        high_next = (high_sum >= ADLER_MOD) ? 16'(high_sum - ADLER_MOD) : high_sum[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= CRC_ONES;
            low_reg  <= 16'd1;
            high_reg <= 16'd0;
        end
        else
        begin
            if (ctl.crc_en)
            begin
                crc_reg <= crc_next;
            end
            if (ctl.adler_clear)
            begin
                low_reg  <= 16'd1;
                high_reg <= 16'd0;
            end
            else if (ctl.adler_en)
            begin
                low_reg  <= low_next;
                high_reg <= high_next;
            end
        end
    end

    assign crc   = crc_reg;
    assign adler = {high_reg, low_reg};
endmodule

@@ hw/rtl/png_stored_rgba_encoder_unit.sv @@
// Top level of the stored-block PNG encoder.
// Takes RGBA8 pixels in raster order and sends a complete PNG file; a new pixel
// is taken only once every byte of the last one is emitted. The first pixel is
// held for length arithmetic (S_CALC1 to S_CALC3) and 43 header bytes; each pixel
// then gives 4 bytes (5 at a row start, for the filter byte), plus 5 bytes each
// time a stored block header falls due. The last pixel adds 20 trailer bytes, the
// final one flagged by last_byte. Bytes pass a single output register and are fed
// to the byte-wide checksum unit. Dimensions are latched at the first pixel;
// pixels after the file is complete are taken and dropped. A new image needs reset.
module png_stored_rgba_encoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] pixel_rgba,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last_byte
);
    import pngse_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CALC1 = 3'd1;
    localparam logic [2:0] S_CALC2 = 3'd2;
    localparam logic [2:0] S_CALC3 = 3'd3;
    localparam logic [2:0] S_HDR   = 3'd4;
    localparam logic [2:0] S_DATA  = 3'd5;
    localparam logic [2:0] S_BLKH  = 3'd6;
    localparam logic [2:0] S_TAIL  = 3'd7;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    logic [2:0]  state_reg;
    logic [14:0] width_cfg_reg, height_cfg_reg;
    logic [14:0] lat_w_reg, lat_h_reg;
    logic [31:0] pixel_reg;
    logic [30:0] total_reg;
    logic [15:0] blocks_reg;
    logic [31:0] idat_len_reg;
    logic [13:0] col_reg, row_reg;
    logic [15:0] blk_left_reg, len_reg;
    logic [30:0] data_left_reg;
    logic [5:0]  idx_reg;
    logic [2:0]  dsel_reg;
    logic        header_sent_reg, done_reg;
    logic        ov_reg, last_reg;
    logic [7:0]  ob_reg;

    logic        can_emit;
    logic        emit;
    logic [31:0] crc, adler, crc_out;
    csum_ctl_t   ctl;
    logic [7:0]  hdr_byte, tail_byte, blk_byte, pix_byte;
    logic        hdr_crc, hdr_init, tail_crc, tail_init;
    logic [31:0] x_sum;
    logic [16:0] ab_sum;
    logic [14:0] w_cl, h_cl, col_inc, row_inc;
    logic [15:0] nlen;

    assign can_emit  = !ov_reg || out_ready;
    assign emit      = can_emit && ((state_reg == S_HDR) || (state_reg == S_BLKH) ||
                                    (state_reg == S_TAIL) ||
                                    ((state_reg == S_DATA) && (blk_left_reg != 16'd0)));
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign last_byte = last_reg;
    assign crc_out   = crc ^ CRC_ONES;
    assign nlen      = ~len_reg;
    assign col_inc   = {1'b0, col_reg} + 15'd1;
    assign row_inc   = {1'b0, row_reg} + 15'd1;

    always_comb
    begin
        w_cl = (width_cfg_reg == 15'd0) ? 15'd1 :
               (width_cfg_reg > MAX_DIM) ? MAX_DIM : width_cfg_reg;
        h_cl = (height_cfg_reg == 15'd0) ? 15'd1 :
               (height_cfg_reg > MAX_DIM) ? MAX_DIM : height_cfg_reg;
        // ceil(total / 65535): 65536a + b = 65535a + (a + b)
        x_sum  = {1'b0, total_reg} + {16'd0, STORED_BLOCK_MAX} - 32'd1;
        ab_sum = {1'b0, x_sum[31:16]} + {1'b0, x_sum[15:0]};
    end

    always_comb
    begin
        hdr_crc  = 1'b0;
        hdr_init = 1'b0;
        case (idx_reg)
            6'd0:  hdr_byte = 8'h89;
            6'd1:  hdr_byte = 8'h50;
            6'd2:  hdr_byte = 8'h4e;
            6'd3:  hdr_byte = 8'h47;
            6'd4:  hdr_byte = 8'h0d;
            6'd5:  hdr_byte = 8'h0a;
            6'd6:  hdr_byte = 8'h1a;
            6'd7:  hdr_byte = 8'h0a;
            6'd11: hdr_byte = 8'h0d;
            6'd12: begin hdr_byte = 8'h49; hdr_crc = 1'b1; hdr_init = 1'b1; end
            6'd13: begin hdr_byte = 8'h48; hdr_crc = 1'b1; end
            6'd14: begin hdr_byte = 8'h44; hdr_crc = 1'b1; end
            6'd15: begin hdr_byte = 8'h52; hdr_crc = 1'b1; end
            6'd16, 6'd17, 6'd20, 6'd21, 6'd26, 6'd27, 6'd28:
                begin hdr_byte = 8'h00; hdr_crc = 1'b1; end
            6'd18: begin hdr_byte = {1'b0, lat_w_reg[14:8]}; hdr_crc = 1'b1; end
            6'd19: begin hdr_byte = lat_w_reg[7:0]; hdr_crc = 1'b1; end
            6'd22: begin hdr_byte = {1'b0, lat_h_reg[14:8]}; hdr_crc = 1'b1; end
            6'd23: begin hdr_byte = lat_h_reg[7:0]; hdr_crc = 1'b1; end
            6'd24: begin hdr_byte = 8'h08; hdr_crc = 1'b1; end
            6'd25: begin hdr_byte = 8'h06; hdr_crc = 1'b1; end
            6'd29: hdr_byte = crc_out[31:24];
            6'd30: hdr_byte = crc_out[23:16];
            6'd31: hdr_byte = crc_out[15:8];
            6'd32: hdr_byte = crc_out[7:0];
            6'd33: hdr_byte = idat_len_reg[31:24];
            6'd34: hdr_byte = idat_len_reg[23:16];
            6'd35: hdr_byte = idat_len_reg[15:8];
            6'd36: hdr_byte = idat_len_reg[7:0];
            6'd37: begin hdr_byte = 8'h49; hdr_crc = 1'b1; hdr_init = 1'b1; end
            6'd38: begin hdr_byte = 8'h44; hdr_crc = 1'b1; end
            6'd39: begin hdr_byte = 8'h41; hdr_crc = 1'b1; end
            6'd40: begin hdr_byte = 8'h54; hdr_crc = 1'b1; end
            6'd41: begin hdr_byte = 8'h78; hdr_crc = 1'b1; end
            6'd42: begin hdr_byte = 8'h01; hdr_crc = 1'b1; end
            default: hdr_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        tail_crc  = 1'b0;
        tail_init = 1'b0;
        case (idx_reg)
            6'd0:  begin tail_byte = adler[31:24]; tail_crc = 1'b1; end
            6'd1:  begin tail_byte = adler[23:16]; tail_crc = 1'b1; end
            6'd2:  begin tail_byte = adler[15:8];  tail_crc = 1'b1; end
            6'd3:  begin tail_byte = adler[7:0];   tail_crc = 1'b1; end
            6'd4, 6'd16: tail_byte = crc_out[31:24];
            6'd5, 6'd17: tail_byte = crc_out[23:16];
            6'd6, 6'd18: tail_byte = crc_out[15:8];
            6'd7, 6'd19: tail_byte = crc_out[7:0];
            6'd12: begin tail_byte = 8'h49; tail_crc = 1'b1; tail_init = 1'b1; end
            6'd13: begin tail_byte = 8'h45; tail_crc = 1'b1; end
            6'd14: begin tail_byte = 8'h4e; tail_crc = 1'b1; end
            6'd15: begin tail_byte = 8'h44; tail_crc = 1'b1; end
            default: tail_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        case (idx_reg[2:0])
            3'd0:    blk_byte = ({15'd0, len_reg} == data_left_reg) ? 8'h01 : 8'h00;
            3'd1:    blk_byte = len_reg[7:0];
            3'd2:    blk_byte = len_reg[15:8];
            3'd3:    blk_byte = nlen[7:0];
            default: blk_byte = nlen[15:8];
        endcase
        case (dsel_reg)
            3'd1:    pix_byte = pixel_reg[31:24];
            3'd2:    pix_byte = pixel_reg[23:16];
            3'd3:    pix_byte = pixel_reg[15:8];
            3'd4:    pix_byte = pixel_reg[7:0];
            default: pix_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        case (state_reg)
            S_CALC1: ctl.adler_clear = 1'b1;
            S_HDR:
            begin
                ctl.data     = hdr_byte;
                ctl.crc_en   = can_emit && hdr_crc;
                ctl.crc_init = hdr_init;
            end
            S_BLKH:
            begin
                ctl.data   = blk_byte;
                ctl.crc_en = can_emit;
            end
            S_DATA:
            begin
                ctl.data     = pix_byte;
                ctl.crc_en   = can_emit && (blk_left_reg != 16'd0);
                ctl.adler_en = ctl.crc_en;
            end
            S_TAIL:
            begin
                ctl.data     = tail_byte;
                ctl.crc_en   = can_emit && tail_crc;
                ctl.crc_init = tail_init;
            end
            default: ctl = '0;
        endcase
    end

    pngse_csum u_csum (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .crc   (crc),
        .adler (adler)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            width_cfg_reg   <= 15'd1;
            height_cfg_reg  <= 15'd1;
            lat_w_reg       <= 15'd1;
            lat_h_reg       <= 15'd1;
            pixel_reg       <= 32'd0;
            total_reg       <= 31'd0;
            blocks_reg      <= 16'd0;
            idat_len_reg    <= 32'd0;
            len_reg         <= 16'd0;
            header_sent_reg <= 1'b0;
            done_reg        <= 1'b0;
            ov_reg          <= 1'b0;
            ob_reg          <= 8'd0;
            last_reg        <= 1'b0;
            col_reg         <= 14'd0;
            row_reg         <= 14'd0;
            blk_left_reg    <= 16'd0;
            data_left_reg   <= 31'd0;
            idx_reg         <= 6'd0;
            dsel_reg        <= 3'd0;
        end
        else
        begin
            if (cfg_write && cfg_index == REG_WIDTH)
            begin
                width_cfg_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == REG_HEIGHT)
            begin
                height_cfg_reg <= cfg_data;
            end
            if (emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !done_reg)
                    begin
                        pixel_reg <= pixel_rgba;
                        dsel_reg  <= (col_reg == 14'd0) ? 3'd0 : 3'd1;
                        state_reg <= header_sent_reg ? S_DATA : S_CALC1;
                    end
                end
                S_CALC1:
                begin
                    lat_w_reg     <= w_cl;
                    lat_h_reg     <= h_cl;
                    total_reg     <= 31'(({16'd0, w_cl} * 31'd4 + 31'd1) * {16'd0, h_cl});
                    state_reg     <= S_CALC2;
                end
                S_CALC2:
                begin
                    data_left_reg <= total_reg;
                    blocks_reg    <= x_sum[31:16] + ((ab_sum >= {1'b0, STORED_BLOCK_MAX})
                                                     ? 16'd1 : 16'd0);
                    state_reg     <= S_CALC3;
                end
                S_CALC3:
                begin
                    idat_len_reg <= {1'b0, total_reg} + 32'({blocks_reg, 2'b00})
                                    + {16'd0, blocks_reg} + 32'd6;
                    idx_reg      <= 6'd0;
                    state_reg    <= S_HDR;
                end
                S_HDR:
                begin
                    if (can_emit)
                    begin
                        ob_reg   <= hdr_byte;
                        last_reg <= 1'b0;
                        idx_reg  <= idx_reg + 6'd1;
                        if (idx_reg == 6'd42)
                        begin
                            header_sent_reg <= 1'b1;
                            state_reg       <= S_DATA;
                        end
                    end
                end
                S_DATA:
                begin
                    if (blk_left_reg == 16'd0)
                    begin
                        // open a new stored block before the next data byte
                        len_reg   <= (data_left_reg < {15'd0, STORED_BLOCK_MAX})
                                     ? data_left_reg[15:0] : STORED_BLOCK_MAX;
                        idx_reg   <= 6'd0;
                        state_reg <= S_BLKH;
                    end
                    else if (can_emit)
                    begin
                        ob_reg        <= pix_byte;
                        last_reg      <= 1'b0;
                        blk_left_reg  <= blk_left_reg - 16'd1;
                        data_left_reg <= data_left_reg - 31'd1;
                        dsel_reg      <= dsel_reg + 3'd1;
                        if (dsel_reg == 3'd4)
                        begin
                            if (col_inc >= lat_w_reg)
                            begin
                                col_reg <= 14'd0;
                                row_reg <= row_inc[13:0];
                                if (row_inc >= lat_h_reg)
                                begin
                                    idx_reg   <= 6'd0;
                                    state_reg <= S_TAIL;
                                end
                                else
                                begin
                                    state_reg <= S_IDLE;
                                end
                            end
                            else
                            begin
                                col_reg   <= col_inc[13:0];
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                end
                S_BLKH:
                begin
                    if (can_emit)
                    begin
                        ob_reg   <= blk_byte;
                        last_reg <= 1'b0;
                        idx_reg  <= idx_reg + 6'd1;
                        if (idx_reg == 6'd4)
                        begin
                            blk_left_reg <= len_reg;
                            state_reg    <= S_DATA;
                        end
                    end
                end
                S_TAIL:
                begin
                    if (can_emit)
                    begin
                        ob_reg   <= tail_byte;
                        last_reg <= (idx_reg == 6'd19);
                        idx_reg  <= idx_reg + 6'd1;
                        if (idx_reg == 6'd19)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ sim/testbench.sv @@
// Testbench for the stored-block PNG encoder: predicts the file byte stream and checks it.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SPARE  = 2'd3;
    localparam int TARGET_PIXELS = 480;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 60;
    localparam int STALL_LIMIT   = 4000;
    localparam int BLOCK_MAX     = 65535;
    localparam int ADLER_BASE    = 65521;
    localparam int DIM_MAX       = 16384;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } file_byte_t;

    class png_scoreboard;
        logic [14:0] reg_width, reg_height;
        int width, height, col, row;
        int block_left, data_left;
        logic [31:0] crc;
        int adler_lo, adler_hi;
        bit started, done;
        file_byte_t stream_q[$];
        int errors, bytes_seen, pixels_noted;

        function new();
            reg_width = 15'd1;
            reg_height = 15'd1;
            crc = 32'hffffffff;
            adler_lo = 1;
        endfunction

        function void write_reg(logic [1:0] idx, logic [14:0] val);
            if (idx == REG_WIDTH) reg_width = val;
            else if (idx == REG_HEIGHT) reg_height = val;
        endfunction

        function void crc_feed(logic [7:0] b);
            crc ^= {24'd0, b};
            for (int k = 0; k < 8; k++)
                crc = crc[0] ? ((crc >> 1) ^ 32'hedb88320) : (crc >> 1);
        endfunction

        function void push(logic [7:0] b, bit with_crc, bit last = 0);
            file_byte_t e;
            if (with_crc) crc_feed(b);
            e.data = b;
            e.last = last;
            stream_q = {stream_q, e};
        endfunction

        function void push_be32(logic [31:0] v, bit with_crc);
            for (int s = 24; s >= 0; s -= 8) push(v[s +: 8], with_crc);
        endfunction

        function void push_tag(string t);
            for (int k = 0; k < 4; k++) push(t[k], 1);
        endfunction

        function void push_data(logic [7:0] b);
            int len;
            logic [15:0] nlen;
            if (block_left == 0) begin
                len = data_left < BLOCK_MAX ? data_left : BLOCK_MAX;
                nlen = ~len[15:0];
                push(len == data_left ? 8'h01 : 8'h00, 1);
                push(len[7:0], 1);
                push(len[15:8], 1);
                push(nlen[7:0], 1);
                push(nlen[15:8], 1);
                block_left = len;
            end
            push(b, 1);
            adler_lo = (adler_lo + b) % ADLER_BASE;
            adler_hi = (adler_hi + adler_lo) % ADLER_BASE;
            if (block_left > 0) block_left--;
            if (data_left > 0) data_left--;
        endfunction

        function int clamp(logic [14:0] v);
            if (v == 0) return 1;
            if (v > DIM_MAX) return DIM_MAX;
            return v;
        endfunction

        function void open_file();
            logic [7:0] sig [8] = '{8'h89, 8'h50, 8'h4e, 8'h47, 8'h0d, 8'h0a, 8'h1a, 8'h0a};
            int total;
            width = clamp(reg_width);
            height = clamp(reg_height);
            foreach (sig[k]) push(sig[k], 0);
            push_be32(32'd13, 0);
            crc = 32'hffffffff;
            push_tag("IHDR");
            push_be32(width, 1);
            push_be32(height, 1);
            push(8'd8, 1);
            push(8'd6, 1);
            push(8'd0, 1);
            push(8'd0, 1);
            push(8'd0, 1);
            push_be32(~crc, 0);
            total = (4 * width + 1) * height;
            push_be32(2 + 5 * ((total + BLOCK_MAX - 1) / BLOCK_MAX) + total + 4, 0);
            crc = 32'hffffffff;
            push_tag("IDAT");
            push(8'h78, 1);
            push(8'h01, 1);
            data_left = total;
            block_left = 0;
            col = 0;
            row = 0;
            adler_lo = 1;
            adler_hi = 0;
            started = 1;
        endfunction

        function void close_file();
            logic [31:0] c;
            push_be32({adler_hi[15:0], adler_lo[15:0]}, 1);
            push_be32(~crc, 0);
            push_be32(32'd0, 0);
            crc = 32'hffffffff;
            push_tag("IEND");
            c = ~crc;
            push(c[31:24], 0);
            push(c[23:16], 0);
            push(c[15:8], 0);
            push(c[7:0], 0, 1);
            done = 1;
        endfunction

        // Note one accepted pixel request and queue the bytes it produces.
        function void note_pixel(logic [31:0] px);
            pixels_noted++;
            if (done) return;
            if (!started) open_file();
            if (col == 0) push_data(8'h00);
            push_data(px[31:24]);
            push_data(px[23:16]);
            push_data(px[15:8]);
            push_data(px[7:0]);
            col++;
            if (col >= width) begin
                col = 0;
                row++;
                if (row >= height) close_file();
            end
        endfunction

        function void check_byte(logic [7:0] b, logic last);
            file_byte_t e;
            bytes_seen++;
            if (stream_q.size() == 0) begin
                $display("%0t: unexpected byte %02h last %0b", $time, b, last);
                errors++;
                return;
            end
            e = stream_q.pop_front();
            if (b !== e.data) begin
                $display("%0t: out_byte expected %02h got %02h", $time, e.data, b);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: last_byte expected %0b got %0b", $time, e.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return stream_q.size();
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_write = 0;
    logic [1:0]  cfg_index = '0;
    logic [14:0] cfg_data = '0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [31:0] pixel_rgba = '0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [7:0]  out_byte;
    logic        last_byte;

    png_scoreboard sb = new();
    bit hold_request = 0;
    int idle_cycles = 0;

    png_stored_rgba_encoder_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .pixel_rgba(pixel_rgba),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_byte(out_byte), .last_byte(last_byte)
    );

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: random hold-offs, calm stretches, and one long hold when asked.
    initial
    begin
        int gap;
        bit calm;
        bit held;
        calm = 0;
        held = 0;
        @(posedge rst_n);
        forever begin
            if ($urandom_range(0, 40) == 0) calm = !calm;
            gap = calm ? 0 : $urandom_range(0, 3);
            if (hold_request && !held) begin
                gap = LONG_HOLD;
                held = 1;
            end
            if (gap > 0) begin
                out_ready <= 0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1;
            do @(posedge clk); while (!(out_valid && out_ready));
            sb.check_byte(out_byte, last_byte);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [14:0] val);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 0;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic send_pixel(logic [31:0] px, bit calm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        pixel_rgba <= px;
        do @(posedge clk); while (!(in_valid && in_ready));
        sb.note_pixel(px);
    endtask

    // Let the block drain completely before touching registers.
    task automatic wait_idle();
        in_valid <= 0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] directed [8] = '{32'h00000000, 32'hffffffff, 32'h80000000,
            32'h00000001, 32'haa55aa55, 32'h55aa55aa, 32'h01020304, 32'hfffefdfc};
        int w, h, n;
        bit calm;
        w = $urandom_range(1, 40);
        h = (TARGET_PIXELS + w - 1) / w;
        n = w * h;
        calm = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Extremes first, then the dimensions that get latched.
        write_reg(REG_WIDTH, 15'd0);
        write_reg(REG_HEIGHT, 15'h7fff);
        write_reg(REG_SPARE, 15'h7fff);
        write_reg(REG_WIDTH, 15'd16384);
        write_reg(REG_HEIGHT, 15'd0);
        write_reg(REG_WIDTH, w[14:0]);
        write_reg(REG_HEIGHT, h[14:0]);

        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 30) == 0) calm = !calm;
            if (i == 100) hold_request = 1;
            if (i == n / 2) begin
                // Writes during an image must not disturb it.
                wait_idle();
                write_reg(REG_WIDTH, 15'd16384);
                write_reg(REG_HEIGHT, 15'd1);
            end
            if (i < $size(directed))
                send_pixel(directed[i], calm);
            else
                send_pixel($urandom, calm);
        end
        // Drop pixels offered after the file is complete.
        repeat (12) send_pixel($urandom, 0);
        in_valid <= 0;

        while (sb.pending() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("image %0d x %0d: %0d pixels offered, %0d file bytes checked",
            w, h, sb.pixels_noted, sb.bytes_seen);
        $display("covered register extremes, mid-image writes, long output hold, trailing pixels");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

@@ png_stored_rgba_encoder_unit.f @@
hw/rtl/pngse_pkg.sv
hw/rtl/pngse_csum.sv
hw/rtl/png_stored_rgba_encoder_unit.sv
sim/testbench.sv
